>>> rtl/core/iphcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iphcp_pkg
// Types, constants and helpers shared by the ip header chain parser.
// ----------------------------------------------------------------------------
package iphcp_pkg;

  localparam int MaxPacketBytes = 4096;
  // wide enough for the saturated header end (limit plus one)
  localparam int IdxW = $clog2(MaxPacketBytes + 2);

  localparam logic [15:0] EtIpv4 = 16'h0800;
  localparam logic [15:0] EtIpv6 = 16'h86DD;

  localparam logic [7:0] PrIcmpv4 = 8'd1;
  localparam logic [7:0] PrTcp    = 8'd6;
  localparam logic [7:0] PrUdp    = 8'd17;
  localparam logic [7:0] PrIcmpv6 = 8'd58;
  localparam logic [7:0] PrNoNext = 8'd59;

  localparam logic [2:0] StL4      = 3'd0;
  localparam logic [2:0] StNoL4    = 3'd1;
  localparam logic [2:0] StIcmp    = 3'd2;
  localparam logic [2:0] StUnknown = 3'd3;
  localparam logic [2:0] StTrunc   = 3'd4;

  localparam int V4MinBytes = 20;
  localparam int V6MinBytes = 40;

  typedef enum logic [2:0] {
    PH_START,
    PH_V4,
    PH_WALK,
    PH_EXTLEN,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] ether_type;
    logic        last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_ipv6;
    logic [7:0]  hop_limit;
    logic [7:0]  next_protocol;
    logic [11:0] l4_offset;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
  } out_beat_t;

  function automatic logic is_l4(input logic [7:0] p);
    return (p == PrTcp) || (p == PrUdp) || (p == PrIcmpv6);
  endfunction

  function automatic logic chain_stops(input logic [7:0] p);
    return is_l4(p) || (p == PrNoNext);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/iphcp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iphcp_parse
// Per-packet parse state and result decode for one byte beat per cycle in which step_i is high.
// ----------------------------------------------------------------------------
module iphcp_parse
  import iphcp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_beat_t  beat_i,
  output out_beat_t      res_o
);

  localparam int SumW = IdxW + 1;

  phase_e           phase_q, phase_d, ph_eff, ph_n;
  logic [IdxW-1:0]  idx_q, idx_d, count;
  logic [IdxW-1:0]  he_q, he_d, he_eff, he_n;
  logic             v6_q, v6_d, unk_q, unk_d;
  logic [7:0]       hop_q, hop_d, nxt_q, nxt_d, ity_q, ity_d, ico_q, ico_d;
  logic [7:0]       hop_eff, nxt_eff, ity_eff, ico_eff;
  logic             start, is_v4, is_v6, live, stops;
  logic [SumW-1:0]  he_p1, he_p2, ext_sum, idx_w, count_w;
  logic [2:0]       status;

  assign start = (phase_q == PH_START);
  assign is_v4 = (beat_i.ether_type == EtIpv4);
  assign is_v6 = (beat_i.ether_type == EtIpv6);
  assign live  = (idx_q < IdxW'(MaxPacketBytes));
  assign count = live ? idx_q + IdxW'(1) : IdxW'(MaxPacketBytes);

  // first byte of a packet restarts the captures and picks the header kind
  always_comb begin
    if (start) begin
      ph_eff  = is_v4 ? PH_V4 : (is_v6 ? PH_WALK : PH_SKIP);
      he_eff  = is_v4 ? IdxW'({beat_i.data_byte[3:0], 2'b00})
                      : (is_v6 ? IdxW'(V6MinBytes) : '0);
      hop_eff = '0;
      nxt_eff = '0;
      ity_eff = '0;
      ico_eff = '0;
      v6_d    = is_v6;
      unk_d   = !is_v4 && !is_v6;
    end else begin
      ph_eff  = phase_q;
      he_eff  = he_q;
      hop_eff = hop_q;
      nxt_eff = nxt_q;
      ity_eff = ity_q;
      ico_eff = ico_q;
      v6_d    = v6_q;
      unk_d   = unk_q;
    end
  end

  assign stops   = chain_stops(nxt_eff);
  assign he_p1   = SumW'(he_eff) + SumW'(1);
  assign idx_w   = SumW'(idx_q);
  assign ext_sum = SumW'(he_eff) + SumW'({({1'b0, beat_i.data_byte} + 9'd1), 3'b000});

  // next phase
  always_comb begin
    ph_n = ph_eff;
    unique case (ph_eff)
      PH_WALK: begin
        if (live && idx_q == he_eff && !stops) ph_n = PH_EXTLEN;
      end
      PH_EXTLEN: ph_n = PH_WALK;
      PH_START, PH_V4, PH_SKIP: ph_n = ph_eff;
      default: ph_n = ph_eff;
    endcase
    phase_d = beat_i.last_byte ? PH_START : ph_n;
  end

  // field captures
  always_comb begin
    hop_d = hop_eff;
    nxt_d = nxt_eff;
    ity_d = ity_eff;
    ico_d = ico_eff;
    he_n  = he_eff;
    unique case (ph_eff)
      PH_V4: begin
        if (live) begin
          if (idx_q == IdxW'(8)) hop_d = beat_i.data_byte;
          if (idx_q == IdxW'(9)) nxt_d = beat_i.data_byte;
          if (idx_q == he_eff) ity_d = beat_i.data_byte;
          if (idx_w == he_p1) ico_d = beat_i.data_byte;
        end
      end
      PH_WALK: begin
        if (live) begin
          if (idx_q == IdxW'(6)) nxt_d = beat_i.data_byte;
          if (idx_q == IdxW'(7)) hop_d = beat_i.data_byte;
          if (idx_q == he_eff) begin
            if (stops) ity_d = beat_i.data_byte;
            else       nxt_d = beat_i.data_byte;
          end else if (idx_w == he_p1 && stops) begin
            ico_d = beat_i.data_byte;
          end
        end
      end
      PH_EXTLEN: begin
        // extension length is in 8-byte units, not counting the first 8
        if (ext_sum > SumW'(MaxPacketBytes)) he_n = IdxW'(MaxPacketBytes + 1);
        else                                 he_n = ext_sum[IdxW-1:0];
      end
      PH_START, PH_SKIP: ;
      default: ;
    endcase
  end

  assign he_d    = he_n;
  assign idx_d   = beat_i.last_byte ? '0 : count;
  assign he_p2   = SumW'(he_n) + SumW'(2);
  assign count_w = SumW'(count);

  // result decode from the state after this byte
  always_comb begin
    if (unk_d) begin
      status = StUnknown;
    end else if (!v6_d) begin
      if (count < IdxW'(V4MinBytes))  status = StTrunc;
      else if (nxt_d == PrIcmpv4)     status = (count_w >= he_p2) ? StIcmp : StTrunc;
      else if (he_n > count)          status = StTrunc;
      else                            status = is_l4(nxt_d) ? StL4 : StNoL4;
    end else begin
      if (count < IdxW'(V6MinBytes) || ph_n == PH_EXTLEN ||
          !chain_stops(nxt_d) || he_n > count) begin
        status = StTrunc;
      end else if (nxt_d == PrIcmpv6) begin
        status = (count_w >= he_p2) ? StIcmp : StTrunc;
      end else if (nxt_d == PrNoNext) begin
        status = StNoL4;
      end else begin
        status = StL4;
      end
    end
  end

  always_comb begin
    res_o               = '0;
    res_o.status        = status;
    res_o.is_ipv6       = !unk_d && v6_d;
    res_o.hop_limit     = unk_d ? 8'd0 : hop_d;
    if (status != StTrunc && status != StUnknown) begin
      res_o.next_protocol = nxt_d;
      res_o.l4_offset     = he_n[11:0];
      if (status == StIcmp) begin
        res_o.icmp_type = ity_d;
        res_o.icmp_code = ico_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      idx_q   <= '0;
      he_q    <= '0;
      v6_q    <= 1'b0;
      unk_q   <= 1'b0;
      hop_q   <= '0;
      nxt_q   <= '0;
      ity_q   <= '0;
      ico_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      he_q    <= he_d;
      v6_q    <= v6_d;
      unk_q   <= unk_d;
      hop_q   <= hop_d;
      nxt_q   <= nxt_d;
      ity_q   <= ity_d;
      ico_q   <= ico_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ip_header_chain_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ip_header_chain_parser_core
// IPv4 / IPv6 header parser with extension header walk, one byte per beat.
// ----------------------------------------------------------------------------
// throughput: one byte beat per cycle, back to back, set by the single
//   decode stage between the input register and the result register, but
//   a last byte waits in the input register for room in the result register
// reset: asynchronous, active low; clears the parse state to packet start
//   and empties both registers
module ip_header_chain_parser_core
  import iphcp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_beat_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_beat_o
);

  in_beat_t   in_q;
  logic       in_valid_q;
  out_beat_t  out_q, res;
  logic       out_valid_q;
  logic       out_free, step, in_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  // only a last-byte beat needs room in the result register
  assign step       = in_valid_q && (!in_q.last_byte || out_free);
  assign in_ready_o = !in_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  iphcp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .beat_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire)   in_valid_q <= 1'b1;
      else if (step) in_valid_q <= 1'b0;
      if (step && in_q.last_byte) out_valid_q <= 1'b1;
      else if (out_ready_i)       out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) in_q <= in_beat_i;
    if (step && in_q.last_byte) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  a_result_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && in_q.last_byte))
    else $error("result beat without a last byte");

  a_status_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.status <= StTrunc))
    else $error("status code out of range");

  a_fail_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status == StTrunc || out_beat_o.status == StUnknown)
    |-> (out_beat_o.next_protocol == 8'd0 && out_beat_o.l4_offset == 12'd0))
    else $error("failed parse reports chain fields");

  a_icmp_fields_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_beat_o.status != StIcmp)
    |-> (out_beat_o.icmp_type == 8'd0 && out_beat_o.icmp_code == 8'd0))
    else $error("icmp fields set without icmp status");

endmodule
`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte-stream check of the ip header chain parser core. Packets of layer-3
// bytes are built as IPv4, IPv6 with extension header chains, unknown
// ethertypes and malformed streams. A software parser mirrors the core byte
// by byte, and every result beat is compared field by field against it.
// ----------------------------------------------------------------------------
module testbench
  import iphcp_pkg::*;
();

  localparam int CycleLimit = 600000;
  localparam int TailCycles = 8;
  localparam int RandomBytes = 1850;
  localparam int MaxReports = 40;

  // extension header codes used to build ipv6 chains
  localparam logic [7:0] PrHopByHop = 8'd0;
  localparam logic [7:0] PrRouting  = 8'd43;
  localparam logic [7:0] PrFragment = 8'd44;
  localparam logic [7:0] PrDestOpts = 8'd60;

  typedef struct packed {
    logic     hold;
    in_beat_t beat;
  } pending_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_beat_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_beat_o;

  ip_header_chain_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  always #10 clk_i = ~clk_i;

  pending_t    byte_q[$];
  logic [7:0]  pkt_buf[$];
  out_beat_t   owed_results[$];
  int          owed_n = 0;
  int          cycle_n = 0;
  int          send_wait = 0;
  int          recv_wait = 0;
  int          err_n = 0;
  int          bytes_total = 0;
  int          status_tally[0:4] = '{default: 0};

  // parser mirror state
  phase_e          walk_phase = PH_START;
  logic [IdxW-1:0] byte_pos = '0;
  logic [IdxW-1:0] hdr_end = '0;
  logic            six = 1'b0;
  logic            foreign = 1'b0;
  logic [7:0]      hop_seen = '0;
  logic [7:0]      proto_seen = '0;
  logic [7:0]      type_seen = '0;
  logic [7:0]      code_seen = '0;

  function automatic bit carries_l4(input logic [7:0] p);
    return p == PrTcp || p == PrUdp || p == PrIcmpv6;
  endfunction

  function automatic bit ends_chain(input logic [7:0] p);
    return carries_l4(p) || p == PrNoNext;
  endfunction

  function automatic void parse_byte(input in_beat_t beat);
    int         idx;
    int         cnt;
    int         hend;
    bit         live;
    logic [2:0] st;
    out_beat_t  r;
    idx = int'(byte_pos);
    live = idx < MaxPacketBytes;
    if (walk_phase == PH_START) begin
      hop_seen = '0;
      proto_seen = '0;
      type_seen = '0;
      code_seen = '0;
      six = beat.ether_type == EtIpv6;
      foreign = beat.ether_type != EtIpv4 && beat.ether_type != EtIpv6;
      if (beat.ether_type == EtIpv4) begin
        walk_phase = PH_V4;
        hdr_end = IdxW'(beat.data_byte[3:0] * 4);
      end else if (six) begin
        walk_phase = PH_WALK;
        hdr_end = IdxW'(V6MinBytes);
      end else begin
        walk_phase = PH_SKIP;
        hdr_end = '0;
      end
    end
    hend = int'(hdr_end);

    if (walk_phase == PH_V4 && live) begin
      if (idx == 8) hop_seen = beat.data_byte;
      if (idx == 9) proto_seen = beat.data_byte;
      if (idx == hend) type_seen = beat.data_byte;
      if (idx == hend + 1) code_seen = beat.data_byte;
    end else if (walk_phase == PH_WALK && live) begin
      if (idx == 6) proto_seen = beat.data_byte;
      if (idx == 7) hop_seen = beat.data_byte;
      if (idx == hend) begin
        if (ends_chain(proto_seen)) begin
          type_seen = beat.data_byte;
        end else begin
          // this byte names the header after the extension
          proto_seen = beat.data_byte;
          walk_phase = PH_EXTLEN;
        end
      end else if (idx == hend + 1 && ends_chain(proto_seen)) begin
        code_seen = beat.data_byte;
      end
    end else if (walk_phase == PH_EXTLEN) begin
      hend = hend + (int'(beat.data_byte) + 1) * 8;
      if (hend > MaxPacketBytes) hend = MaxPacketBytes + 1;
      hdr_end = hend[IdxW-1:0];
      walk_phase = PH_WALK;
    end

    cnt = live ? idx + 1 : MaxPacketBytes;
    if (!beat.last_byte) begin
      byte_pos = cnt[IdxW-1:0];
      return;
    end

    if (foreign) begin
      st = StUnknown;
    end else if (!six) begin
      if (cnt < V4MinBytes) st = StTrunc;
      else if (proto_seen == PrIcmpv4) st = (cnt >= hend + 2) ? StIcmp : StTrunc;
      else if (hend > cnt) st = StTrunc;
      else st = carries_l4(proto_seen) ? StL4 : StNoL4;
    end else begin
      if (cnt < V6MinBytes || walk_phase == PH_EXTLEN || !ends_chain(proto_seen) ||
          hend > cnt) st = StTrunc;
      else if (proto_seen == PrIcmpv6) st = (cnt >= hend + 2) ? StIcmp : StTrunc;
      else if (proto_seen == PrNoNext) st = StNoL4;
      else st = StL4;
    end

    r = '0;
    r.status = st;
    r.is_ipv6 = !foreign && six;
    r.hop_limit = foreign ? 8'd0 : hop_seen;
    if (st != StTrunc && st != StUnknown) begin
      r.next_protocol = proto_seen;
      r.l4_offset = hend[11:0];
      if (st == StIcmp) begin
        r.icmp_type = type_seen;
        r.icmp_code = code_seen;
      end
    end
    owed_results.push_back(r);
    status_tally[st]++;
    walk_phase = PH_START;
    byte_pos = '0;
  endfunction

  // random idle gaps, and quiet stretches with no idling on either side
  function automatic int draw_gap();
    return (cycle_n % 1000 >= 800) ? 0 : $urandom_range(0, 4);
  endfunction

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      if (err_n < MaxReports)
        $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
      err_n++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_n,
               owed_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // byte driver
  always @(posedge clk_i) begin : drv
    logic     v;
    in_beat_t b;
    pending_t p;
    v = in_valid_i;
    b = in_beat_i;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) v = 1'b0;
      if (!v) begin
        if (send_wait > 0) begin
          send_wait <= send_wait - 1;
        end else if (byte_q.size() > 0 &&
                     !(byte_q[0].hold && (owed_n != 0 || in_valid_i || out_valid_o))) begin
          p = byte_q.pop_front();
          v = 1'b1;
          b = p.beat;
          send_wait <= draw_gap();
        end
      end
    end
    in_valid_i <= v;
    in_beat_i <= b;
  end

  // result sink with random stalls
  always @(posedge clk_i) begin : rcv
    int n;
    n = recv_wait;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) n = draw_gap();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        recv_wait <= n - 1;
      end else begin
        out_ready_i <= 1'b1;
        recv_wait <= 0;
      end
    end
  end

  // monitor: mirror accepted bytes, then check the result beat
  always @(posedge clk_i) begin : mon
    out_beat_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) parse_byte(in_beat_i);
      if (out_valid_o && out_ready_i) begin
        if (owed_results.size() == 0) begin
          if (err_n < MaxReports)
            $display("%0t unexpected result beat: expected none actual status %0d",
                     $time, out_beat_o.status);
          err_n++;
        end else begin
          want = owed_results.pop_front();
          check_field("status", want.status, out_beat_o.status);
          check_field("is_ipv6", want.is_ipv6, out_beat_o.is_ipv6);
          check_field("hop_limit", want.hop_limit, out_beat_o.hop_limit);
          check_field("next_protocol", want.next_protocol, out_beat_o.next_protocol);
          check_field("l4_offset", want.l4_offset, out_beat_o.l4_offset);
          check_field("icmp_type", want.icmp_type, out_beat_o.icmp_type);
          check_field("icmp_code", want.icmp_code, out_beat_o.icmp_code);
        end
      end
    end
    owed_n <= owed_results.size();
  end

  task automatic fill_random(input int n);
    pkt_buf.delete();
    repeat (n) pkt_buf.push_back(8'($urandom));
  endtask

  task automatic cut_to(input int n);
    while (pkt_buf.size() > n) void'(pkt_buf.pop_back());
  endtask

  function automatic logic [7:0] pick_stop();
    case ($urandom_range(0, 3))
      0:       return PrTcp;
      1:       return PrUdp;
      2:       return PrIcmpv6;
      default: return PrNoNext;
    endcase
  endfunction

  function automatic logic [7:0] pick_ext();
    logic [7:0] p;
    case ($urandom_range(0, 5))
      0: return PrHopByHop;
      1: return PrRouting;
      2: return PrFragment;
      3: return PrDestOpts;
      4: return PrIcmpv4;
      default: begin
        p = 8'($urandom);
        while (ends_chain(p)) p = 8'($urandom);
        return p;
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_v4_proto();
    case ($urandom_range(0, 5))
      0:       return PrIcmpv4;
      1:       return PrTcp;
      2:       return PrUdp;
      3:       return PrIcmpv6;
      4:       return PrNoNext;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_v4(input int ihl, input logic [7:0] proto, input int len);
    fill_random(len);
    // version nibble is mostly 4 but never checked by the parser
    pkt_buf[0] = {($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd4, 4'(ihl)};
    if (len > 9) pkt_buf[9] = proto;
  endtask

  task automatic build_v6(input int n_ext, input int ext_lo, input int ext_hi, input int pay);
    int nh_at;
    int elen;
    fill_random(V6MinBytes);
    nh_at = 6;
    for (int k = 0; k < n_ext; k++) begin
      pkt_buf[nh_at] = pick_ext();
      nh_at = pkt_buf.size();
      elen = $urandom_range(ext_lo, ext_hi);
      pkt_buf.push_back(8'($urandom));
      pkt_buf.push_back(8'(elen));
      repeat ((elen + 1) * 8 - 2) pkt_buf.push_back(8'($urandom));
    end
    pkt_buf[nh_at] = pick_stop();
    repeat (pay) pkt_buf.push_back(8'($urandom));
  endtask

  task automatic emit_packet(input logic [15:0] et, input bit hold);
    pending_t p;
    for (int i = 0; i < pkt_buf.size(); i++) begin
      p.hold = hold && i == 0;
      p.beat.data_byte = pkt_buf[i];
      // ethertype only counts on the first byte
      p.beat.ether_type = (i == 0) ? et : 16'($urandom);
      p.beat.last_byte = i == pkt_buf.size() - 1;
      byte_q.push_back(p);
    end
    bytes_total += pkt_buf.size();
  endtask

  initial begin : stim
    int          kind;
    int          ihl;
    int          len;
    int          rand_bytes;
    logic [15:0] et;
    bit          first;

    // single-byte packets of every kind
    pkt_buf.delete();
    pkt_buf.push_back(8'hFF);
    emit_packet(16'hFFFF, 1'b0);
    pkt_buf[0] = 8'h00;
    emit_packet(16'h0000, 1'b0);
    pkt_buf[0] = 8'h45;
    emit_packet(EtIpv4, 1'b0);
    pkt_buf[0] = 8'h60;
    emit_packet(EtIpv6, 1'b0);
    // ihl of zero with icmp: type and code come from the first two bytes
    pkt_buf.delete();
    repeat (20) pkt_buf.push_back(8'hFF);
    pkt_buf[0] = 8'h00;
    pkt_buf[9] = PrIcmpv4;
    emit_packet(EtIpv4, 1'b0);

    rand_bytes = 0;
    first = 1'b1;
    while (rand_bytes < RandomBytes) begin
      kind = $urandom_range(0, 99);
      et = EtIpv4;
      if (kind < 40) begin
        ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 15);
        len = ihl * 4 + $urandom_range(0, 8);
        if (len < V4MinBytes && $urandom_range(0, 3) != 0) len = V4MinBytes + $urandom_range(0, 4);
        if (len < 1) len = 1;
        build_v4(ihl, pick_v4_proto(), len);
      end else if (kind < 80) begin
        et = EtIpv6;
        build_v6($urandom_range(0, 3), 0, ($urandom_range(0, 7) == 0) ? 20 : 3,
                 $urandom_range(0, 10));
      end else if (kind < 90) begin
        et = 16'($urandom);
        fill_random($urandom_range(1, 24));
      end else begin
        // ip ethertype carrying garbage
        et = kind[0] ? EtIpv4 : EtIpv6;
        fill_random($urandom_range(1, 60));
      end
      if (kind < 80 && $urandom_range(0, 6) == 0) cut_to($urandom_range(1, pkt_buf.size()));
      emit_packet(et, first);
      first = 1'b0;
      rand_bytes += pkt_buf.size();
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || in_valid_i || owed_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d byte beats in %0d packets", bytes_total,
             status_tally[StL4] + status_tally[StNoL4] + status_tally[StIcmp] +
             status_tally[StUnknown] + status_tally[StTrunc]);
    $display("results: l4 %0d, no l4 %0d, icmp %0d, unknown ethertype %0d, truncated %0d",
             status_tally[StL4], status_tally[StNoL4], status_tally[StIcmp],
             status_tally[StUnknown], status_tally[StTrunc]);
    if (err_n == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", err_n);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
